// ===== hw/rtl/vau_pkg.sv =====
// Package for the fixed-point 3D vector arithmetic unit.
// Holds widths, action and status codes, the pipeline sideband struct
// and the saturation helper. No dependencies.
package vau_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DW        = 32;
	localparam int EPS_W     = 31;
	localparam int LANES     = 3;
	localparam int SQ_W      = 2 * DW;
	localparam int ROOT_W    = DW;
	localparam int DVS_W     = DW;
	localparam int DVD_W     = DW + FRAC_BITS;
	localparam int WIDE_W    = 2 * DW + 2;

	localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(66);

	typedef enum logic [3:0] {
		ACT_NEG   = 4'd0,
		ACT_ADD   = 4'd1,
		ACT_SUB   = 4'd2,
		ACT_MUL   = 4'd3,
		ACT_DIV   = 4'd4,
		ACT_SCALE = 4'd5,
		ACT_SDIV  = 4'd6,
		ACT_DOT   = 4'd7,
		ACT_CROSS = 4'd8,
		ACT_LEN   = 4'd9,
		ACT_NORM  = 4'd10,
		ACT_EQ    = 4'd11,
		ACT_NE    = 4'd12
	} action_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_SAT  = 2'd1,
		ST_DIV0 = 2'd2
	} status_t;

	typedef logic signed [DW-1:0]     word_t;
	typedef logic signed [2*DW-1:0]   prod_t;
	typedef logic signed [2*DW:0]     xsum_t;
	typedef logic signed [WIDE_W-1:0] wide_t;
	typedef logic signed [DW:0]       lin_t;
	typedef logic [DW:0]              mag_t;
	typedef logic [DVD_W-1:0]         dvd_t;
	typedef logic [DVS_W-1:0]         dvs_t;
	typedef logic [SQ_W-1:0]          sq_t;
	typedef logic [ROOT_W-1:0]        root_t;

	localparam word_t WORD_MAX    = {1'b0, {(DW-1){1'b1}}};
	localparam word_t WORD_MIN    = {1'b1, {(DW-1){1'b0}}};
	localparam dvd_t  QUO_POS_LIM = dvd_t'(WORD_MAX);
	localparam dvd_t  QUO_NEG_LIM = dvd_t'(1) << (DW - 1);

	typedef struct packed {
		word_t val;
		logic  sat;
	} sat_t;

	// Sideband that travels with an item through the root and divide stages.
	typedef struct packed {
		action_t              act;
		logic [LANES-1:0][DW-1:0] r;
		logic [DW-1:0]        sc;
		logic                 cmp;
		status_t              st;
		logic [LANES-1:0][DVD_W-1:0] dvd;
		logic [LANES-1:0][DVS_W-1:0] dvs;
		logic [LANES-1:0]     aneg;
		logic [LANES-1:0]     dvneg;
	} meta_t;

	// Clamp a wide signed value into one word.
	function automatic sat_t sat_word(input wide_t v);
		sat_t res;
		if (v > wide_t'(WORD_MAX)) begin
			res.val = WORD_MAX;
			res.sat = 1'b1;
		end else if (v < wide_t'(WORD_MIN)) begin
			res.val = WORD_MIN;
			res.sat = 1'b1;
		end else begin
			res.val = word_t'(v[DW-1:0]);
			res.sat = 1'b0;
		end
		return res;
	endfunction

endpackage

// ===== hw/rtl/vau_if.sv =====
// Valid/ready channel interfaces for the vector arithmetic unit.
// Request carries action and operands, response carries results.
// Depends on nothing.
interface vau_req_if;
	logic               valid;
	logic               ready;
	logic [3:0]         action;
	logic signed [31:0] a_x;
	logic signed [31:0] a_y;
	logic signed [31:0] a_z;
	logic signed [31:0] b_x;
	logic signed [31:0] b_y;
	logic signed [31:0] b_z;
	logic signed [31:0] scalar_in;

	modport source (output valid, action, a_x, a_y, a_z, b_x, b_y, b_z, scalar_in,
		input ready);
	modport sink (input valid, action, a_x, a_y, a_z, b_x, b_y, b_z, scalar_in,
		output ready);
endinterface

interface vau_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] r_x;
	logic signed [31:0] r_y;
	logic signed [31:0] r_z;
	logic signed [31:0] scalar_out;
	logic               compare_true;
	logic [1:0]         status;

	modport source (output valid, r_x, r_y, r_z, scalar_out, compare_true, status,
		input ready);
	modport sink (input valid, r_x, r_y, r_z, scalar_out, compare_true, status,
		output ready);
endinterface

// ===== hw/rtl/vau_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
// Depends on vau_pkg.
module vau_isqrt (
	input  logic            clk,
	input  logic            en,
	input  vau_pkg::sq_t    sq_in,
	output vau_pkg::root_t  root_out
);

	localparam int N     = vau_pkg::ROOT_W;
	localparam int REM_W = vau_pkg::ROOT_W + 3;

	logic [vau_pkg::SQ_W-1:0]   rad_s  [N-1];
	logic [REM_W-1:0]           rem_s  [N-1];
	logic [vau_pkg::ROOT_W-1:0] root_s [N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [vau_pkg::SQ_W-1:0]   cur_rad;
		logic [REM_W-1:0]           cur_rem;
		logic [vau_pkg::ROOT_W-1:0] cur_root;
		logic [REM_W-1:0]           remc;
		logic [REM_W-1:0]           trial;
		logic                       ge;

		if (k == 0) begin : g_first
			assign cur_rad  = sq_in;
			assign cur_rem  = '0;
			assign cur_root = '0;
		end else begin : g_next
			assign cur_rad  = rad_s[k-1];
			assign cur_rem  = rem_s[k-1];
			assign cur_root = root_s[k-1];
		end

		// bring down the next two radicand bits, try root*4+1
		assign remc  = {cur_rem[REM_W-3:0], cur_rad[vau_pkg::SQ_W-1 -: 2]};
		assign trial = {1'b0, cur_root, 2'b01};
		assign ge    = (remc >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				root_s[k] <= {cur_root[vau_pkg::ROOT_W-2:0], ge};
			end
		end

		if (k < N - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rad_s[k] <= {cur_rad[vau_pkg::SQ_W-3:0], 2'b00};
					rem_s[k] <= ge ? (remc - trial) : remc;
				end
			end
		end
	end

	assign root_out = root_s[N-1];

endmodule

// ===== hw/rtl/vau_div.sv =====
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Depends on vau_pkg. Quotient is garbage for a zero divisor.
module vau_div (
	input  logic          clk,
	input  logic          en,
	input  vau_pkg::dvd_t dvd_in,
	input  vau_pkg::dvs_t dvs_in,
	output vau_pkg::dvd_t q_out
);

	localparam int N = vau_pkg::DVD_W;

	logic [vau_pkg::DVD_W-1:0] dvd_s [N];
	logic [vau_pkg::DVS_W-1:0] rem_s [N-1];
	logic [vau_pkg::DVS_W-1:0] dvs_s [N-1];

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [vau_pkg::DVD_W-1:0] cur_dvd;
		logic [vau_pkg::DVS_W-1:0] cur_rem;
		logic [vau_pkg::DVS_W-1:0] cur_dvs;
		logic [vau_pkg::DVS_W:0]   rc;
		logic [vau_pkg::DVS_W:0]   diff;
		logic                      ge;

		if (k == 0) begin : g_first
			assign cur_dvd = dvd_in;
			assign cur_rem = '0;
			assign cur_dvs = dvs_in;
		end else begin : g_next
			assign cur_dvd = dvd_s[k-1];
			assign cur_rem = rem_s[k-1];
			assign cur_dvs = dvs_s[k-1];
		end

		assign rc   = {cur_rem, cur_dvd[vau_pkg::DVD_W-1]};
		assign diff = rc - {1'b0, cur_dvs};
		assign ge   = (rc >= {1'b0, cur_dvs});

		// shift dividend out at the top, quotient bits in at the bottom
		always_ff @(posedge clk) begin
			if (en) begin
				dvd_s[k] <= {cur_dvd[vau_pkg::DVD_W-2:0], ge};
			end
		end

		if (k < N - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= ge ? diff[vau_pkg::DVS_W-1:0] : rc[vau_pkg::DVS_W-1:0];
					dvs_s[k] <= cur_dvs;
				end
			end
		end
	end

	assign q_out = dvd_s[N-1];

endmodule

// ===== hw/rtl/vector3_arithmetic_unit_top.sv =====
// Top level of the fixed-point 3D vector arithmetic unit.
// Depends on vau_pkg, vau_if, vau_isqrt and vau_div.
//
// Usage:
//   req (sink) takes one word per accepted valid/ready handshake: an action
//   code, two Q16.16 vectors a and b and a Q16.16 scalar. rsp (source) gives
//   one word per request: result vector, scalar result, compare flag and
//   status (ok, saturated, divide by zero).
//   epsilon_we/epsilon_wdata write the compare tolerance; write it only while
//   no request is in flight.
// Timing:
//   Every action takes the same path, so results leave in request order:
//   the capture register loads at the accepting edge, then three stages of
//   multiply, sum and saturate logic, 32 square-root stages (one root bit
//   each), 48 divider stages (one quotient bit each) and the output
//   register, 85 registers in all. Throughput is one word per cycle while
//   rsp takes each word; a held rsp word stalls the pipeline.
// Reset:
//   arst_n clears every valid bit and loads epsilon with 66. No clearing pass.
// Backpressure:
//   When rsp holds a word that is not taken, the whole pipeline holds and
//   req.ready drops; nothing is lost or repeated. A bubble in the output
//   register lets the pipeline advance.
module vector3_arithmetic_unit_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          epsilon_we,
	input  logic [vau_pkg::EPS_W-1:0]     epsilon_wdata,
	vau_req_if.sink                       req,
	vau_rsp_if.source                     rsp
);

	localparam int N_SQ = vau_pkg::ROOT_W;
	localparam int N_DV = vau_pkg::DVD_W;
	localparam int L    = vau_pkg::LANES;

	logic                       en;
	logic [vau_pkg::EPS_W-1:0]  eps_q;

	// stage 1: captured request
	logic                 v_s1;
	vau_pkg::action_t     act_s1;
	vau_pkg::word_t       a_s1 [L];
	vau_pkg::word_t       b_s1 [L];
	vau_pkg::word_t       s_s1;

	// stage 2: products and linear sums
	logic                 v_s2;
	vau_pkg::action_t     act_s2;
	vau_pkg::prod_t       p_s2   [L];
	vau_pkg::prod_t       q_s2   [L];
	vau_pkg::lin_t        lin_s2 [L];
	vau_pkg::word_t       a_s2   [L];
	vau_pkg::word_t       dv_s2  [L];

	// stage 3: combined products, magnitudes, divider operands
	logic                 v_s3;
	vau_pkg::action_t     act_s3;
	vau_pkg::xsum_t       x_s3     [L];
	vau_pkg::wide_t       dsum_s3;
	vau_pkg::word_t       linr_s3  [L];
	logic [L-1:0]         lins_s3;
	vau_pkg::mag_t        cmag_s3  [L];
	vau_pkg::dvd_t        dvd_s3   [L];
	vau_pkg::dvs_t        dvs_s3   [L];
	logic [L-1:0]         aneg_s3;
	logic [L-1:0]         dvneg_s3;

	// stage 4: results other than divide, length and normalize settled, radicand ready
	logic                 v_s4;
	vau_pkg::meta_t       meta_n;
	vau_pkg::meta_t       meta_s4;
	vau_pkg::sq_t         sq_s4;

	// sideband delay lines alongside root and divider stages
	logic [N_SQ-1:0]      vld_sq_s;
	vau_pkg::meta_t       meta_sq_s [N_SQ];
	logic [N_DV-1:0]      vld_dv_s;
	vau_pkg::meta_t       meta_dv_s [N_DV];

	vau_pkg::root_t       root;
	vau_pkg::meta_t       meta_j;
	vau_pkg::dvd_t        quo [L];

	// final assembly and output register
	logic [L-1:0][vau_pkg::DW-1:0] fin_r;
	logic [vau_pkg::DW-1:0]        fin_sc;
	logic                          fin_cmp;
	vau_pkg::status_t              fin_st;

	logic                          out_v_q;
	logic [vau_pkg::DW-1:0]        rx_q;
	logic [vau_pkg::DW-1:0]        ry_q;
	logic [vau_pkg::DW-1:0]        rz_q;
	logic [vau_pkg::DW-1:0]        sc_q;
	logic                          cmp_q;
	vau_pkg::status_t              st_q;

	// advance the whole pipe unless the output word is stuck
	assign en        = !out_v_q || rsp.ready;
	assign req.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= vau_pkg::EPS_RESET;
		end else if (epsilon_we) begin
			eps_q <= epsilon_wdata;
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			v_s4     <= 1'b0;
			vld_sq_s <= '0;
			vld_dv_s <= '0;
			out_v_q  <= 1'b0;
		end else if (en) begin
			v_s1     <= req.valid;
			v_s2     <= v_s1;
			v_s3     <= v_s2;
			v_s4     <= v_s3;
			vld_sq_s <= {vld_sq_s[N_SQ-2:0], v_s4};
			vld_dv_s <= {vld_dv_s[N_DV-2:0], vld_sq_s[N_SQ-1]};
			out_v_q  <= vld_dv_s[N_DV-1];
		end
	end

	// stage 1: capture the request word
	always_ff @(posedge clk) begin
		if (en) begin
			act_s1  <= vau_pkg::action_t'(req.action);
			a_s1[0] <= req.a_x;
			a_s1[1] <= req.a_y;
			a_s1[2] <= req.a_z;
			b_s1[0] <= req.b_x;
			b_s1[1] <= req.b_y;
			b_s1[2] <= req.b_z;
			s_s1    <= req.scalar_in;
		end
	end

	// stages 2 and 3, one lane per component
	for (genvar i = 0; i < L; i++) begin : g_lane
		localparam int I1 = (i + 1) % 3;
		localparam int I2 = (i + 2) % 3;

		vau_pkg::word_t ml;
		vau_pkg::word_t mr;
		vau_pkg::lin_t  lin;
		vau_pkg::word_t dv;
		vau_pkg::xsum_t x;
		vau_pkg::sat_t  ls;
		logic [vau_pkg::DW:0]   lu;
		logic [vau_pkg::DW-1:0] au;
		logic [vau_pkg::DW-1:0] du;
		logic [vau_pkg::DW-1:0] amag;
		logic [vau_pkg::DW-1:0] dmag;

		// cross product reuses the lane multipliers with rotated operands
		always_comb begin
			ml = (act_s1 == vau_pkg::ACT_CROSS) ? a_s1[I1] : a_s1[i];
			case (act_s1)
				vau_pkg::ACT_SCALE: mr = s_s1;
				vau_pkg::ACT_LEN,
				vau_pkg::ACT_NORM:  mr = a_s1[i];
				vau_pkg::ACT_CROSS: mr = b_s1[I2];
				default:            mr = b_s1[i];
			endcase
			case (act_s1)
				vau_pkg::ACT_NEG: lin = -vau_pkg::lin_t'(a_s1[i]);
				vau_pkg::ACT_ADD: lin = vau_pkg::lin_t'(a_s1[i]) + vau_pkg::lin_t'(b_s1[i]);
				default:          lin = vau_pkg::lin_t'(a_s1[i]) - vau_pkg::lin_t'(b_s1[i]);
			endcase
			dv = (act_s1 == vau_pkg::ACT_SDIV) ? s_s1 : b_s1[i];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				p_s2[i]   <= ml * mr;
				q_s2[i]   <= a_s1[I2] * b_s1[I1];
				lin_s2[i] <= lin;
				a_s2[i]   <= a_s1[i];
				dv_s2[i]  <= dv;
			end
		end

		always_comb begin
			x    = (act_s2 == vau_pkg::ACT_CROSS) ?
				vau_pkg::xsum_t'(p_s2[i]) - vau_pkg::xsum_t'(q_s2[i]) :
				vau_pkg::xsum_t'(p_s2[i]);
			ls   = vau_pkg::sat_word(vau_pkg::wide_t'(lin_s2[i]));
			lu   = lin_s2[i];
			au   = a_s2[i];
			du   = dv_s2[i];
			amag = au[vau_pkg::DW-1] ? (~au + 1'b1) : au;
			dmag = du[vau_pkg::DW-1] ? (~du + 1'b1) : du;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s3[i]     <= x;
				linr_s3[i]  <= ls.val;
				lins_s3[i]  <= ls.sat;
				cmag_s3[i]  <= lu[vau_pkg::DW] ? (~lu + 1'b1) : lu;
				dvd_s3[i]   <= {amag, {vau_pkg::FRAC_BITS{1'b0}}};
				dvs_s3[i]   <= dmag;
				aneg_s3[i]  <= au[vau_pkg::DW-1];
				dvneg_s3[i] <= du[vau_pkg::DW-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			act_s2  <= act_s1;
			act_s3  <= act_s2;
			dsum_s3 <= vau_pkg::wide_t'(p_s2[0]) + vau_pkg::wide_t'(p_s2[1])
				+ vau_pkg::wide_t'(p_s2[2]);
		end
	end

	// stage 4: truncate, saturate, compare; set up divider operands
	always_comb begin
		vau_pkg::sat_t            xs [L];
		vau_pkg::sat_t            ds;
		logic [vau_pkg::DW:0]     eps_x;
		logic                     all_lt;
		logic                     any_gt;

		eps_x  = {{(vau_pkg::DW+1-vau_pkg::EPS_W){1'b0}}, eps_q};
		all_lt = 1'b1;
		any_gt = 1'b0;
		for (int i = 0; i < L; i++) begin
			xs[i] = vau_pkg::sat_word(vau_pkg::wide_t'(x_s3[i] >>> vau_pkg::FRAC_BITS));
			if (!(cmag_s3[i] < eps_x)) all_lt = 1'b0;
			if (cmag_s3[i] > eps_x)    any_gt = 1'b1;
		end
		ds = vau_pkg::sat_word(dsum_s3 >>> vau_pkg::FRAC_BITS);

		meta_n       = '0;
		meta_n.act   = act_s3;
		meta_n.st    = vau_pkg::ST_OK;
		meta_n.aneg  = aneg_s3;
		meta_n.dvneg = dvneg_s3;
		for (int i = 0; i < L; i++) begin
			meta_n.dvd[i] = dvd_s3[i];
			meta_n.dvs[i] = dvs_s3[i];
		end

		case (act_s3)
			vau_pkg::ACT_NEG,
			vau_pkg::ACT_ADD,
			vau_pkg::ACT_SUB: begin
				for (int i = 0; i < L; i++) meta_n.r[i] = linr_s3[i];
				meta_n.st = (|lins_s3) ? vau_pkg::ST_SAT : vau_pkg::ST_OK;
			end
			vau_pkg::ACT_MUL,
			vau_pkg::ACT_SCALE,
			vau_pkg::ACT_CROSS: begin
				for (int i = 0; i < L; i++) meta_n.r[i] = xs[i].val;
				meta_n.st = (xs[0].sat || xs[1].sat || xs[2].sat) ?
					vau_pkg::ST_SAT : vau_pkg::ST_OK;
			end
			vau_pkg::ACT_DOT: begin
				meta_n.sc = ds.val;
				meta_n.st = ds.sat ? vau_pkg::ST_SAT : vau_pkg::ST_OK;
			end
			vau_pkg::ACT_EQ: meta_n.cmp = all_lt;
			vau_pkg::ACT_NE: meta_n.cmp = any_gt;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s4 <= meta_n;
			sq_s4   <= dsum_s3[vau_pkg::SQ_W-1:0];
		end
	end

	// square root of the sum of squares
	vau_isqrt u_isqrt (
		.clk      (clk),
		.en       (en),
		.sq_in    (sq_s4),
		.root_out (root)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			meta_sq_s[0] <= meta_s4;
			for (int k = 1; k < N_SQ; k++) meta_sq_s[k] <= meta_sq_s[k-1];
		end
	end

	// length result lands here; normalize divides by the root
	always_comb begin
		meta_j = meta_sq_s[N_SQ-1];
		case (meta_j.act)
			vau_pkg::ACT_LEN: begin
				meta_j.sc = root[vau_pkg::ROOT_W-1] ? vau_pkg::WORD_MAX : root;
				meta_j.st = root[vau_pkg::ROOT_W-1] ? vau_pkg::ST_SAT : vau_pkg::ST_OK;
			end
			vau_pkg::ACT_NORM: begin
				for (int i = 0; i < L; i++) meta_j.dvs[i] = root;
			end
			default: ;
		endcase
	end

	for (genvar i = 0; i < L; i++) begin : g_div
		vau_div u_div (
			.clk    (clk),
			.en     (en),
			.dvd_in (meta_j.dvd[i]),
			.dvs_in (meta_j.dvs[i]),
			.q_out  (quo[i])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_dv_s[0] <= meta_j;
			for (int k = 1; k < N_DV; k++) meta_dv_s[k] <= meta_dv_s[k-1];
		end
	end

	// sign, clamp and zero-divisor handling of quotients
	always_comb begin
		vau_pkg::meta_t              md;
		logic [L-1:0][vau_pkg::DW-1:0] dr;
		vau_pkg::dvd_t               nq;
		logic                        dz_any;
		logic                        sat_any;
		logic                        ng;

		md      = meta_dv_s[N_DV-1];
		dz_any  = 1'b0;
		sat_any = 1'b0;
		for (int i = 0; i < L; i++) begin
			ng = md.aneg[i] ^ ((md.act != vau_pkg::ACT_NORM) && md.dvneg[i]);
			nq = ~quo[i] + 1'b1;
			if (md.dvs[i] == '0) begin
				dz_any = 1'b1;
				if (md.aneg[i])           dr[i] = vau_pkg::WORD_MIN;
				else if (md.dvd[i] == '0) dr[i] = '0;
				else                      dr[i] = vau_pkg::WORD_MAX;
			end else if (ng) begin
				if (quo[i] > vau_pkg::QUO_NEG_LIM) begin
					dr[i]   = vau_pkg::WORD_MIN;
					sat_any = 1'b1;
				end else begin
					dr[i] = nq[vau_pkg::DW-1:0];
				end
			end else begin
				if (quo[i] > vau_pkg::QUO_POS_LIM) begin
					dr[i]   = vau_pkg::WORD_MAX;
					sat_any = 1'b1;
				end else begin
					dr[i] = quo[i][vau_pkg::DW-1:0];
				end
			end
		end

		fin_r   = md.r;
		fin_sc  = md.sc;
		fin_cmp = md.cmp;
		fin_st  = md.st;
		case (md.act)
			vau_pkg::ACT_DIV,
			vau_pkg::ACT_SDIV: begin
				fin_r  = dr;
				fin_st = dz_any ? vau_pkg::ST_DIV0 :
					(sat_any ? vau_pkg::ST_SAT : vau_pkg::ST_OK);
			end
			vau_pkg::ACT_NORM: begin
				// zero vector: zero result, flag divide error
				if (dz_any) begin
					fin_r  = '0;
					fin_st = vau_pkg::ST_DIV0;
				end else begin
					fin_r  = dr;
					fin_st = vau_pkg::ST_OK;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rx_q  <= fin_r[0];
			ry_q  <= fin_r[1];
			rz_q  <= fin_r[2];
			sc_q  <= fin_sc;
			cmp_q <= fin_cmp;
			st_q  <= fin_st;
		end
	end

	assign rsp.valid        = out_v_q;
	assign rsp.r_x          = rx_q;
	assign rsp.r_y          = ry_q;
	assign rsp.r_z          = rz_q;
	assign rsp.scalar_out   = sc_q;
	assign rsp.compare_true = cmp_q;
	assign rsp.status       = st_q;

endmodule
